### rtl/core/mme_pkg.sv
// ----------------------------------------------------------------------------
// mme_pkg
// Shared sizes, codes and types of the matrix multiply element engine.
// ----------------------------------------------------------------------------
package mme_pkg;

  localparam int MAX_DIM     = 64;
  localparam int DIM_W       = $clog2(MAX_DIM + 1);
  localparam int ROW_W       = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int SPAN_W      = 2 * DIM_W;

  localparam int IDX_W   = 12;  // flat_index / result_index port width
  localparam int ELEM_W  = 16;
  localparam int PROD_W  = 2 * ELEM_W;
  localparam int SUM_W   = 39;
  localparam int MODE_W  = 2;
  localparam int CFG_W   = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CLAMP_W = (CFG_W > DIM_W) ? CFG_W : DIM_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int DIV_CNT_W   = $clog2(IDX_W + 1);

  localparam logic [MODE_W-1:0] MODE_LOAD_A  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_B  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_DIMENSION   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_FIRST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_LIMIT = 2'd2;

  localparam logic [CFG_W-1:0] DIMENSION_RESET   = 7'd64;
  localparam logic [CFG_W-1:0] INNER_FIRST_RESET = 7'd0;
  localparam logic [CFG_W-1:0] INNER_LIMIT_RESET = 7'd64;

  // Effective (clamped) configuration seen by the back end.
  typedef struct packed {
    logic [DIM_W-1:0]  dim;
    logic [DIM_W-1:0]  first;
    logic [DIM_W-1:0]  limit;
    logic [SPAN_W-1:0] span;
  } cfg_t;

  // Classified command travelling from front to back.
  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic [IDX_W-1:0]         idx;
    logic signed [ELEM_W-1:0] element;
    logic                     err;
  } cmd_t;

endpackage

### rtl/core/mme_front.sv
// ----------------------------------------------------------------------------
// mme_front
// Configuration registers and item classification: drops unused codes and
// out-of-range loads, flags out-of-range computes, feeds the command queue.
// ----------------------------------------------------------------------------
module mme_front import mme_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic [MODE_W-1:0]           mode,
  input  logic [IDX_W-1:0]            flat_index,
  input  logic signed [ELEM_W-1:0]    element,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_data,
  input  logic                        q_full,
  output logic                        q_push,
  output cmd_t                        q_data,
  output cfg_t                        cfg
);

  logic [CFG_W-1:0]   dimension;
  logic [CFG_W-1:0]   inner_first;
  logic [CFG_W-1:0]   inner_limit;
  logic [CLAMP_W-1:0] dim_wide;
  logic [CLAMP_W-1:0] dim_eff;
  logic [CLAMP_W-1:0] first_wide;
  logic [CLAMP_W-1:0] limit_wide;
  logic               in_range;
  logic               keep;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension   <= DIMENSION_RESET;
      inner_first <= INNER_FIRST_RESET;
      inner_limit <= INNER_LIMIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DIMENSION:   dimension   <= cfg_data;
        REG_INNER_FIRST: inner_first <= cfg_data;
        REG_INNER_LIMIT: inner_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero means one, above the store size saturates
  always_comb begin
    dim_wide   = CLAMP_W'(dimension);
    first_wide = CLAMP_W'(inner_first);
    limit_wide = CLAMP_W'(inner_limit);
    if (dim_wide == '0) begin
      dim_eff = CLAMP_W'(1);
    end else if (dim_wide > CLAMP_W'(MAX_DIM)) begin
      dim_eff = CLAMP_W'(MAX_DIM);
    end else begin
      dim_eff = dim_wide;
    end
    if (first_wide > dim_eff) first_wide = dim_eff;
    if (limit_wide > dim_eff) limit_wide = dim_eff;
  end

  assign cfg.dim   = dim_eff[DIM_W-1:0];
  assign cfg.first = first_wide[DIM_W-1:0];
  assign cfg.limit = limit_wide[DIM_W-1:0];
  assign cfg.span  = SPAN_W'(cfg.dim) * SPAN_W'(cfg.dim);

  assign in_range = (SPAN_W'(flat_index) < cfg.span);

  always_comb begin
    unique case (mode)
      MODE_LOAD_A, MODE_LOAD_B: keep = in_range;
      MODE_COMPUTE:             keep = 1'b1;
      default:                  keep = 1'b0;
    endcase
  end

  assign q_push         = push && !q_full && keep;
  assign q_data.mode    = mode;
  assign q_data.idx     = flat_index;
  assign q_data.element = element;
  assign q_data.err     = !in_range;

endmodule

### rtl/core/mme_cmd_queue.sv
// ----------------------------------------------------------------------------
// mme_cmd_queue
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
module mme_cmd_queue import mme_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic full,
  input  logic rd_en,
  output cmd_t rd_data,
  output logic empty
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_wr;
  logic              do_rd;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_rd) rd_ptr <= rd_ptr + QPTR_W'(1);
      if (do_wr && !do_rd) count <= count + QCNT_W'(1);
      else if (do_rd && !do_wr) count <= count - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_data;
  end

endmodule

### rtl/core/mme_back.sv
// ----------------------------------------------------------------------------
// mme_back
// Executes commands: matrix stores, index split by iterative division,
// one multiply-accumulate per inner index, and the result register.
// ----------------------------------------------------------------------------
module mme_back import mme_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  cfg_t                     cfg,
  input  cmd_t                     cmd,
  input  logic                     cmd_empty,
  output logic                     cmd_pop,
  output logic                     empty,
  input  logic                     pop,
  output logic [IDX_W-1:0]         result_index,
  output logic signed [SUM_W-1:0]  product_sum,
  output logic                     index_error
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV   = 5'b00010,
    S_SETUP = 5'b00100,
    S_MAC   = 5'b01000,
    S_DRAIN = 5'b10000
  } state_t;

  state_t state;

  logic signed [ELEM_W-1:0] left_mem  [STORE_DEPTH];
  logic signed [ELEM_W-1:0] right_mem [STORE_DEPTH];

  logic                     res_valid;
  logic [IDX_W-1:0]         cur_idx;
  logic [IDX_W-1:0]         quo;
  logic [DIM_W-1:0]         rem;
  logic [DIM_W:0]           rem_shift;
  logic [DIV_CNT_W-1:0]     div_cnt;
  logic [DIM_W-1:0]         k;
  logic [ADDR_W-1:0]        a_addr;
  logic [ADDR_W-1:0]        b_addr;
  logic [ADDR_W-1:0]        wr_addr;
  logic [ROW_W+DIM_W-1:0]   row_base;
  logic [SPAN_W-1:0]        col_base;
  logic                     issue;
  logic                     rd_v;
  logic                     prod_v;
  logic signed [ELEM_W-1:0] a_q;
  logic signed [ELEM_W-1:0] b_q;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  acc;
  logic                     we_left;
  logic                     we_right;

  assign cmd_pop = (state == S_IDLE) && !cmd_empty &&
                   ((cmd.mode != MODE_COMPUTE) || !res_valid);
  assign we_left  = cmd_pop && (cmd.mode == MODE_LOAD_A);
  assign we_right = cmd_pop && (cmd.mode == MODE_LOAD_B);
  assign wr_addr  = cmd.idx[ADDR_W-1:0];

  assign issue     = (state == S_MAC) && (k < cfg.limit);
  assign rem_shift = {rem, quo[IDX_W-1]};
  assign row_base  = (ROW_W+DIM_W)'(quo[ROW_W-1:0]) * (ROW_W+DIM_W)'(cfg.dim);
  assign col_base  = SPAN_W'(cfg.first) * SPAN_W'(cfg.dim);

  always_ff @(posedge clk) begin
    if (we_left) left_mem[wr_addr] <= cmd.element;
    a_q <= left_mem[a_addr];
  end

  always_ff @(posedge clk) begin
    if (we_right) right_mem[wr_addr] <= cmd.element;
    b_q <= right_mem[b_addr];
  end

  always_ff @(posedge clk) begin
    prod <= PROD_W'(a_q) * PROD_W'(b_q);
    if (state == S_SETUP) begin
      acc <= '0;
    end else if (prod_v) begin
      acc <= acc + {{(SUM_W-PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      rd_v      <= 1'b0;
      prod_v    <= 1'b0;
    end else begin
      rd_v   <= issue;
      prod_v <= rd_v;
      if (pop && res_valid) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd_pop && (cmd.mode == MODE_COMPUTE)) begin
            cur_idx <= cmd.idx;
            if (cmd.err) begin
              res_valid    <= 1'b1;
              result_index <= cmd.idx;
              product_sum  <= '0;
              index_error  <= 1'b1;
            end else begin
              quo     <= cmd.idx;
              rem     <= '0;
              div_cnt <= DIV_CNT_W'(IDX_W);
              state   <= S_DIV;
            end
          end
        end
        S_DIV: begin
          // restoring division, one quotient bit per cycle
          if (rem_shift >= {1'b0, cfg.dim}) begin
            rem <= DIM_W'(rem_shift - {1'b0, cfg.dim});
            quo <= {quo[IDX_W-2:0], 1'b1};
          end else begin
            rem <= rem_shift[DIM_W-1:0];
            quo <= {quo[IDX_W-2:0], 1'b0};
          end
          div_cnt <= div_cnt - DIV_CNT_W'(1);
          if (div_cnt == DIV_CNT_W'(1)) state <= S_SETUP;
        end
        S_SETUP: begin
          a_addr <= row_base[ADDR_W-1:0] + ADDR_W'(cfg.first);
          b_addr <= col_base[ADDR_W-1:0] + ADDR_W'(rem);
          k      <= cfg.first;
          state  <= S_MAC;
        end
        S_MAC: begin
          if (issue) begin
            k      <= k + DIM_W'(1);
            a_addr <= a_addr + ADDR_W'(1);
            b_addr <= b_addr + ADDR_W'(cfg.dim);
          end else begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!rd_v && !prod_v) begin
            res_valid    <= 1'b1;
            result_index <= cur_idx;
            product_sum  <= acc;
            index_error  <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign empty = !res_valid;

`ifndef ASSERT_OFF
  a_compute_slot_free: assert property (@(posedge clk) disable iff (rst)
    (cmd_pop && (cmd.mode == MODE_COMPUTE)) |-> !res_valid)
    else $error("compute taken while result slot occupied");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state) == S_DRAIN) || ($past(state) == S_IDLE))
    else $error("result loaded from unexpected state");

  a_read_only_in_mac: assert property (@(posedge clk) disable iff (rst)
    rd_v |-> ($past(state) == S_MAC))
    else $error("operand read outside accumulate phase");

  a_no_store_write_busy: assert property (@(posedge clk) disable iff (rst)
    (we_left || we_right) |-> (state == S_IDLE) && !rd_v && !prod_v)
    else $error("store written during a dot product");
`endif

endmodule

### rtl/core/matrix_multiply_element_top.sv
// Flow: a kept transfer enters the command queue; the back end pops it when idle.
//   A load then lands in its store; an in-range compute passes divide, setup, MAC, drain.
// Throughput: one load per cycle while the queue is not full; computes are paced
//   by the 12-step divider, the single MAC and the one-entry result slot.
// Reset (rst, synchronous): registers to defaults, queues empty; the
//   matrix stores are not cleared.
// ----------------------------------------------------------------------------
// matrix_multiply_element_top
// Square matrix multiply engine, one element of C = A * B (summed over the inner range) per compute item.
// ----------------------------------------------------------------------------
module matrix_multiply_element_top import mme_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  // input queue side
  input  logic                     push,
  output logic                     full,
  input  logic [MODE_W-1:0]        mode,
  input  logic [IDX_W-1:0]         flat_index,
  input  logic signed [ELEM_W-1:0] element,
  // result queue side
  output logic                     empty,
  input  logic                     pop,
  output logic [IDX_W-1:0]         result_index,
  output logic signed [SUM_W-1:0]  product_sum,
  output logic                     index_error,
  // configuration write channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);

  cfg_t cfg;
  cmd_t q_wdata;
  cmd_t q_rdata;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;

  // Every transfer into the block waits only on the command queue: dropped
  // items (unused mode, out-of-range loads) still take one transfer.
  assign full = q_full;

  // Front end: config registers, range check, classification.
  mme_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .mode       (mode),
    .flat_index (flat_index),
    .element    (element),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_wdata),
    .cfg        (cfg)
  );

  // Decouples acceptance from execution, so loads keep flowing in while a
  // dot product runs or a result waits to be popped.
  mme_cmd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  // Back end: stores, divider, MAC pipeline, result register.
  mme_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (q_rdata),
    .cmd_empty    (q_empty),
    .cmd_pop      (q_pop),
    .empty        (empty),
    .pop          (pop),
    .result_index (result_index),
    .product_sum  (product_sum),
    .index_error  (index_error)
  );

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the matrix multiply element engine. A clocked
// driver feeds load and compute commands from a backlog that the stimulus
// process fills; a clocked monitor pops C elements and compares them with
// a shadow copy of both matrices and the size and inner-range registers.
// ----------------------------------------------------------------------------
module testbench;
  import mme_pkg::*;

  localparam int CLK_HALF      = 2;
  localparam int ITEM_TARGET   = 1250;
  localparam int SETTLE_CYCLES = 100;   // lets trailing loads land
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int MAX_PRINTS    = 40;
  localparam int CFG_MAX       = (1 << CFG_W) - 1;

  // Mode three is not decoded by the engine; the package gives it no name.
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  localparam logic signed [ELEM_W-1:0] ELEM_MIN = 16'sh8000;
  localparam logic signed [ELEM_W-1:0] ELEM_MAX = 16'sh7FFF;

  // One command waiting in front of the engine.
  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic [IDX_W-1:0]         idx;
    logic signed [ELEM_W-1:0] elem;
  } engine_cmd_t;

  // One element of C as the engine should report it.
  typedef struct packed {
    logic [IDX_W-1:0]        index;
    logic signed [SUM_W-1:0] sum;
    logic                    range_err;
  } c_element_t;

  // --------------------------------------------------------------------------
  // DUT hookup; every input has a known value from time zero
  // --------------------------------------------------------------------------
  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     push = 1'b0;
  logic                     full;
  logic [MODE_W-1:0]        mode = MODE_LOAD_A;
  logic [IDX_W-1:0]         flat_index = '0;
  logic signed [ELEM_W-1:0] element = '0;
  logic                     empty;
  logic                     pop = 1'b0;
  logic [IDX_W-1:0]         result_index;
  logic signed [SUM_W-1:0]  product_sum;
  logic                     index_error;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = REG_DIMENSION;
  logic [CFG_W-1:0]         cfg_data = '0;

  matrix_multiply_element_top uut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .mode         (mode),
    .flat_index   (flat_index),
    .element      (element),
    .empty        (empty),
    .pop          (pop),
    .result_index (result_index),
    .product_sum  (product_sum),
    .index_error  (index_error),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #(CLK_HALF) clk = ~clk;

  // --------------------------------------------------------------------------
  // Shadow state
  // --------------------------------------------------------------------------
  // Register copies, updated at the config transfer edge.
  logic [CFG_W-1:0] dim_reg   = DIMENSION_RESET;
  logic [CFG_W-1:0] first_reg = INNER_FIRST_RESET;
  logic [CFG_W-1:0] limit_reg = INNER_LIMIT_RESET;

  // Matrix contents as of the last accepted command.
  logic signed [ELEM_W-1:0] a_store [STORE_DEPTH];
  logic signed [ELEM_W-1:0] b_store [STORE_DEPTH];

  // Entries that some queued load will have written. The stores power up
  // undefined, so the stimulus never lets a compute read outside this set.
  bit a_loaded [STORE_DEPTH];
  bit b_loaded [STORE_DEPTH];

  engine_cmd_t cmd_backlog [$];      // filled by stimulus, drained by driver
  c_element_t  c_elements_due [$];   // products still owed by the engine
  engine_cmd_t next_cmd;

  int items_queued   = 0;
  int items_accepted = 0;
  int stim_items     = 0;   // loads that land plus computes
  int send_wait      = 0;
  int pop_wait       = 0;
  int pop_gap;
  int results_seen   = 0;
  int next_hold_at   = 40;
  int long_holds     = 0;
  int fault_count    = 0;
  int loads_stored   = 0;
  int products_owed  = 0;
  int range_flags    = 0;
  int cfg_writes     = 0;
  bit steady         = 1'b0;   // no random gaps on either side during this phase (long receiver holds still apply)

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  // Size in use: zero reads as one, anything past the store reads as MAX_DIM.
  function automatic int active_dim();
    if (dim_reg == 0) return 1;
    if (int'(dim_reg) > MAX_DIM) return MAX_DIM;
    return int'(dim_reg);
  endfunction

  function automatic int clamp_bound(logic [CFG_W-1:0] v, int d);
    return (int'(v) > d) ? d : int'(v);
  endfunction

  // Mostly back to back, sometimes short gaps, rarely a long one.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Random element with the two extremes weighted up.
  function automatic logic signed [ELEM_W-1:0] rand_elem();
    case ($urandom_range(0, 9))
      0:       return ELEM_MIN;
      1:       return ELEM_MAX;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  // Apply one accepted command to the shadow matrices; computes owe a result.
  function automatic void mirror_item(logic [MODE_W-1:0] m, logic [IDX_W-1:0] idx,
                                      logic signed [ELEM_W-1:0] e);
    int d, lo, hi, row, col, k;
    longint acc;
    c_element_t c;
    d = active_dim();
    case (m)
      MODE_LOAD_A: begin
        if (int'(idx) < d * d) begin
          a_store[idx] = e;
          loads_stored++;
        end
      end
      MODE_LOAD_B: begin
        if (int'(idx) < d * d) begin
          b_store[idx] = e;
          loads_stored++;
        end
      end
      MODE_COMPUTE: begin
        c.index     = idx;
        c.sum       = '0;
        c.range_err = 1'b0;
        if (int'(idx) >= d * d) begin
          c.range_err = 1'b1;
          range_flags++;
        end else begin
          row = int'(idx) / d;
          col = int'(idx) % d;
          lo  = clamp_bound(first_reg, d);
          hi  = clamp_bound(limit_reg, d);
          acc = 0;
          // Empty range falls straight through with a zero sum.
          for (k = lo; k < hi; k++)
            acc += int'(a_store[row * d + k]) * int'(b_store[k * d + col]);
          c.sum = acc[SUM_W-1:0];
        end
        products_owed++;
        c_elements_due.push_back(c);
      end
      default: ;
    endcase
  endfunction

  task automatic flag(string what, logic signed [63:0] want, logic signed [63:0] got);
    fault_count++;
    if (fault_count <= MAX_PRINTS)
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
  endtask

  task automatic check_result();
    c_element_t due;
    results_seen++;
    if (c_elements_due.size() == 0) begin
      fault_count++;
      if (fault_count <= MAX_PRINTS)
        $display("%0t ns: result for index %0d with no product outstanding, expected none",
                 $time, result_index);
      return;
    end
    due = c_elements_due.pop_front();
    if (result_index !== due.index)     flag("result_index", due.index, result_index);
    if (product_sum !== due.sum)        flag("product_sum", due.sum, product_sum);
    if (index_error !== due.range_err)  flag("index_error", due.range_err, index_error);
  endtask

  // --------------------------------------------------------------------------
  // Driver: one command per transfer, random gaps after each transfer
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      push      <= 1'b0;
      send_wait <= 0;
    end else begin
      if (push && !full) begin
        mirror_item(mode, flat_index, element);
        items_accepted++;
      end
      // While full is high the command stays on the ports untouched.
      if (!(push && full)) begin
        if (send_wait > 0) begin
          push      <= 1'b0;
          send_wait <= send_wait - 1;
        end else if (cmd_backlog.size() != 0) begin
          next_cmd   = cmd_backlog.pop_front();
          mode       <= next_cmd.mode;
          flat_index <= next_cmd.idx;
          element    <= next_cmd.elem;
          push       <= 1'b1;
          send_wait  <= pick_gap();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each popped element, then stalls at random. Now and then,
  // with plenty still to send, it holds off long enough for the engine to
  // back up all the way to its input.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      pop      <= 1'b0;
      pop_wait <= 0;
    end else if (pop && !empty) begin
      check_result();
      if (results_seen >= next_hold_at && cmd_backlog.size() >= 8) begin
        long_holds++;
        next_hold_at = results_seen + 350;
        pop      <= 1'b0;
        pop_wait <= HOLD_CYCLES;
      end else begin
        pop_gap = pick_gap();
        pop      <= (pop_gap == 0);
        pop_wait <= pop_gap;
      end
    end else if (pop_wait > 0) begin
      pop_wait <= pop_wait - 1;
      pop      <= (pop_wait == 1);
    end else begin
      pop <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  // Register write; only called with the engine idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] which, int value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data  <= CFG_W'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (which)
      REG_DIMENSION:   dim_reg   = CFG_W'(value);
      REG_INNER_FIRST: first_reg = CFG_W'(value);
      REG_INNER_LIMIT: limit_reg = CFG_W'(value);
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
  endtask

  // Wait for every command to transfer and every product to come back, then
  // give trailing loads time to land.
  task automatic settle();
    while (items_accepted != items_queued || c_elements_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic queue_item(logic [MODE_W-1:0] m, int idx, logic signed [ELEM_W-1:0] e);
    engine_cmd_t c;
    int span;
    span   = active_dim() * active_dim();
    c.mode = m;
    c.idx  = IDX_W'(idx);
    c.elem = e;
    cmd_backlog.push_back(c);
    items_queued++;
    if (m == MODE_COMPUTE) begin
      stim_items++;
    end else if (idx < span && m == MODE_LOAD_A) begin
      a_loaded[idx] = 1'b1;
      stim_items++;
    end else if (idx < span && m == MODE_LOAD_B) begin
      b_loaded[idx] = 1'b1;
      stim_items++;
    end
  endtask

  // Compute with its operands guaranteed: any A row or B column entry in the
  // summed range that was never written gets a random load first.
  task automatic queue_compute(int idx);
    int d, row, col, lo, hi, k;
    d = active_dim();
    if (idx < d * d) begin
      row = idx / d;
      col = idx % d;
      lo  = clamp_bound(first_reg, d);
      hi  = clamp_bound(limit_reg, d);
      for (k = lo; k < hi; k++) begin
        if (!a_loaded[row * d + k]) queue_item(MODE_LOAD_A, row * d + k, rand_elem());
        if (!b_loaded[k * d + col]) queue_item(MODE_LOAD_B, k * d + col, rand_elem());
      end
    end
    queue_item(MODE_COMPUTE, idx, ELEM_W'($urandom));
  endtask

  function automatic int pick_bound(int usual, int d);
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return usual;
    if (r < 85) return $urandom_range(0, d);
    return $urandom_range(0, CFG_MAX);
  endfunction

  // Small sizes dominate; full size, zero and oversize show up now and then.
  task automatic random_setting();
    int r, raw, d;
    r = $urandom_range(0, 99);
    if (r < 60)      raw = $urandom_range(1, 6);
    else if (r < 85) raw = $urandom_range(7, 16);
    else if (r < 92) raw = $urandom_range(17, MAX_DIM - 1);
    else if (r < 96) raw = MAX_DIM;
    else if (r < 98) raw = 0;
    else             raw = $urandom_range(MAX_DIM + 1, CFG_MAX);
    write_reg(REG_DIMENSION, raw);
    d = active_dim();
    write_reg(REG_INNER_FIRST, pick_bound(0, d));
    write_reg(REG_INNER_LIMIT, pick_bound(d, d));
  endtask

  // Mostly in-range computes on loaded data, with stray loads, out-of-range
  // indexes and the unused mode mixed in.
  task automatic random_phase(int n_ops, bit pause_midway);
    int i, d, r;
    d = active_dim();
    for (i = 0; i < n_ops; i++) begin
      if (pause_midway && i == n_ops / 2) settle();
      r = $urandom_range(0, 99);
      if (r < 60)
        queue_compute($urandom_range(0, d * d - 1));
      else if (r < 70)
        queue_compute($urandom_range(0, STORE_DEPTH - 1));
      else if (r < 88)
        queue_item($urandom_range(0, 1) ? MODE_LOAD_B : MODE_LOAD_A,
                   $urandom_range(0, d * d - 1), rand_elem());
      else if (r < 95)
        queue_item($urandom_range(0, 1) ? MODE_LOAD_B : MODE_LOAD_A,
                   $urandom_range(0, STORE_DEPTH - 1), rand_elem());
      else
        queue_item(MODE_SPARE, $urandom_range(0, STORE_DEPTH - 1), ELEM_W'($urandom));
    end
  endtask

  initial begin
    int phase_no;
    int d;
    phase_no = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset sizes: corner loads with extreme values, unused mode.
    queue_item(MODE_LOAD_A, STORE_DEPTH - 1, ELEM_MAX);
    queue_item(MODE_LOAD_B, 0, ELEM_MIN);
    queue_item(MODE_SPARE, STORE_DEPTH - 1, -16'sd1);
    settle();

    // 2x2 full range: most negative squared twice, a few range errors, a
    // load past the end that must not land anywhere.
    write_reg(REG_DIMENSION, 2);
    write_reg(REG_INNER_FIRST, 0);
    write_reg(REG_INNER_LIMIT, 2);
    queue_item(MODE_LOAD_A, 0, ELEM_MIN);
    queue_item(MODE_LOAD_A, 1, ELEM_MIN);
    queue_item(MODE_LOAD_A, 2, ELEM_MAX);
    queue_item(MODE_LOAD_A, 3, 16'sd1);
    queue_item(MODE_LOAD_B, 0, ELEM_MIN);
    queue_item(MODE_LOAD_B, 1, ELEM_MAX);
    queue_item(MODE_LOAD_B, 2, ELEM_MIN);
    queue_item(MODE_LOAD_B, 3, -16'sd1);
    queue_compute(0);
    queue_compute(1);
    queue_compute(2);
    queue_compute(3);
    queue_compute(4);
    queue_compute(STORE_DEPTH - 1);
    queue_item(MODE_LOAD_A, 4, 16'sd123);
    queue_compute(0);
    queue_item(MODE_SPARE, 0, '0);
    settle();

    // Size zero acts as one; limit far past the size clamps down to it.
    write_reg(REG_DIMENSION, 0);
    write_reg(REG_INNER_LIMIT, CFG_MAX);
    queue_compute(0);
    queue_compute(1);
    settle();

    // Oversize clamps to full size; both bounds clamp, range is empty.
    write_reg(REG_DIMENSION, CFG_MAX);
    write_reg(REG_INNER_FIRST, 100);
    queue_compute(STORE_DEPTH - 1);
    queue_compute(0);
    settle();

    // First past limit gives zero, then a partial range on a 3x3.
    write_reg(REG_DIMENSION, 3);
    write_reg(REG_INNER_FIRST, 2);
    write_reg(REG_INNER_LIMIT, 1);
    queue_compute(4);
    settle();
    write_reg(REG_INNER_FIRST, 1);
    write_reg(REG_INNER_LIMIT, 3);
    queue_compute(4);
    queue_compute(8);
    settle();

    // Random phases until the item budget is spent.
    stim_items = 0;
    while (stim_items < ITEM_TARGET) begin
      steady = (phase_no % 6 == 5);
      if (phase_no == 0) begin
        // Full size, full range first, kept short since fills are costly.
        write_reg(REG_DIMENSION, MAX_DIM);
        write_reg(REG_INNER_FIRST, 0);
        write_reg(REG_INNER_LIMIT, MAX_DIM);
      end else begin
        random_setting();
      end
      d = active_dim();
      random_phase(d > 16 ? $urandom_range(4, 10) : $urandom_range(20, 60),
                   phase_no % 4 == 1);
      settle();
      phase_no++;
    end
    steady = 1'b0;

    $display("Covered %0d stored loads and %0d products (%0d out of range) in %0d phases,",
             loads_stored, products_owed, range_flags, phase_no);
    $display("with %0d register writes, %0d long receiver holds, %0d mismatches.",
             cfg_writes, long_holds, fault_count);
    if (fault_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Hang guard, several times the slowest legal run.
  initial begin
    #20_000_000;
    $display("Timeout with %0d products outstanding", c_elements_due.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### matrix_multiply_element_top.f
rtl/core/mme_pkg.sv
rtl/core/mme_front.sv
rtl/core/mme_cmd_queue.sv
rtl/core/mme_back.sv
rtl/core/matrix_multiply_element_top.sv
verif/testbench.sv
